### design/pds_pkg.sv
package pds_pkg;

  localparam int unsigned CntW = 16;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_START     = 2'd1,
    FUNC_START_MIN = 2'd2,
    FUNC_CONT      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_RUN_RELOAD      = 2'd0,
    CFG_EXIT_RUN_RELOAD = 2'd1,
    CFG_PREPARE_RELOAD  = 2'd2,
    CFG_WAKE_TIME       = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_RUN  = 5'b00010,
    PH_EXIT = 5'b00100,
    PH_PREP = 5'b01000,
    PH_GOTO = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    SS_INIT = 2'd0,
    SS_RUN  = 2'd1,
    SS_PREP = 2'd2,
    SS_WAIT = 2'd3
  } sys_state_e;

  localparam logic [2:0] PHASE_CODE_IDLE = 3'd0;
  localparam logic [2:0] PHASE_CODE_RUN  = 3'd1;
  localparam logic [2:0] PHASE_CODE_EXIT = 3'd2;
  localparam logic [2:0] PHASE_CODE_PREP = 3'd3;
  localparam logic [2:0] PHASE_CODE_GOTO = 3'd4;

  localparam logic [CntW-1:0] RunReloadRst     = 16'd1;
  localparam logic [CntW-1:0] ExitRunReloadRst = 16'd0;
  localparam logic [CntW-1:0] PrepareReloadRst = 16'd0;
  localparam logic [CntW-1:0] WakeTimeRst      = 16'd15;

  typedef struct packed {
    logic [CntW-1:0] run_reload;
    logic [CntW-1:0] exit_run_reload;
    logic [CntW-1:0] prepare_reload;
    logic [CntW-1:0] wake_time;
  } cfg_t;

  typedef struct packed {
    func_e           func;
    logic [CntW-1:0] run_time;
    logic            exit_run_ok;
    logic            prepare_ok;
    logic            goto_ok;
    logic            continue_ok;
  } item_t;

  typedef struct packed {
    sys_state_e      sys_state;
    logic [2:0]      phase;
    logic            enter_power_down;
    logic [CntW-1:0] wake_seconds;
  } res_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    code = PHASE_CODE_IDLE;
    unique case (ph)
      PH_IDLE: code = PHASE_CODE_IDLE;
      PH_RUN:  code = PHASE_CODE_RUN;
      PH_EXIT: code = PHASE_CODE_EXIT;
      PH_PREP: code = PHASE_CODE_PREP;
      PH_GOTO: code = PHASE_CODE_GOTO;
      default: code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### design/pds_if.sv
interface pds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] run_time;
  logic        exit_run_ok;
  logic        prepare_ok;
  logic        goto_ok;
  logic        continue_ok;

  modport source (output valid, func, run_time, exit_run_ok, prepare_ok, goto_ok,
                  continue_ok, input ready);
  modport sink (input valid, func, run_time, exit_run_ok, prepare_ok, goto_ok,
                continue_ok, output ready);
endinterface

interface pds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  sys_state;
  logic [2:0]  phase;
  logic        enter_power_down;
  logic [15:0] wake_seconds;

  modport source (output valid, sys_state, phase, enter_power_down, wake_seconds,
                  input ready);
  modport sink (input valid, sys_state, phase, enter_power_down, wake_seconds,
                output ready);
endinterface

### design/pds_cfg.sv
module pds_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  output pds_pkg::cfg_t         cfg_o
);
  import pds_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RUN_RELOAD:      cfg_d.run_reload      = cfg_data_i;
        CFG_EXIT_RUN_RELOAD: cfg_d.exit_run_reload = cfg_data_i;
        CFG_PREPARE_RELOAD:  cfg_d.prepare_reload  = cfg_data_i;
        CFG_WAKE_TIME:       cfg_d.wake_time       = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_reload      <= RunReloadRst;
      cfg_q.exit_run_reload <= ExitRunReloadRst;
      cfg_q.prepare_reload  <= PrepareReloadRst;
      cfg_q.wake_time       <= WakeTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pds_core.sv
module pds_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  pds_pkg::item_t item_i,
  input  pds_pkg::cfg_t  cfg_i,
  output pds_pkg::res_t  res_o
);
  import pds_pkg::*;

  phase_e          phase_q, phase_d;
  sys_state_e      sys_q, sys_d;
  logic [CntW-1:0] run_cnt_q, run_cnt_d;
  logic [CntW-1:0] exit_cnt_q, exit_cnt_d;
  logic [CntW-1:0] prep_cnt_q, prep_cnt_d;
  logic            start_ok;
  logic            goto_hit;

  assign start_ok = (phase_q == PH_IDLE) || (phase_q == PH_RUN) || (phase_q == PH_EXIT);

  always_comb begin
    phase_d    = phase_q;
    sys_d      = sys_q;
    run_cnt_d  = run_cnt_q;
    exit_cnt_d = exit_cnt_q;
    prep_cnt_d = prep_cnt_q;
    goto_hit   = 1'b0;
    unique case (item_i.func)
      FUNC_START: begin
        if (start_ok) begin
          run_cnt_d = cfg_i.run_reload;
          phase_d   = PH_RUN;
        end
      end
      FUNC_START_MIN: begin
        if (start_ok) begin
          if (run_cnt_q < item_i.run_time) run_cnt_d = item_i.run_time;
          phase_d = PH_RUN;
        end
      end
      FUNC_CONT: begin
        if (item_i.continue_ok) begin
          phase_d   = PH_RUN;
          run_cnt_d = cfg_i.run_reload;
        end
      end
      FUNC_TICK: begin
        unique case (phase_q)
          PH_RUN: begin
            sys_d = SS_RUN;
            if (run_cnt_q != '0) begin
              run_cnt_d = run_cnt_q - 1'b1;
            end else if (item_i.exit_run_ok) begin
              phase_d    = PH_EXIT;
              exit_cnt_d = cfg_i.exit_run_reload;
            end
          end
          PH_EXIT: begin
            if (exit_cnt_q != '0) begin
              exit_cnt_d = exit_cnt_q - 1'b1;
            end else begin
              sys_d = SS_PREP;
              if (item_i.prepare_ok) begin
                phase_d    = PH_PREP;
                prep_cnt_d = cfg_i.prepare_reload;
              end
            end
          end
          PH_PREP: begin
            if (prep_cnt_q != '0) begin
              prep_cnt_d = prep_cnt_q - 1'b1;
            end else begin
              sys_d = SS_WAIT;
              if (item_i.goto_ok) begin
                phase_d  = PH_GOTO;
                goto_hit = 1'b1;
              end
            end
          end
          PH_GOTO: goto_hit = 1'b1;
          default: goto_hit = 1'b0;
        endcase
        if (goto_hit && item_i.continue_ok) begin
          phase_d   = PH_RUN;
          run_cnt_d = cfg_i.run_reload;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sys_q      <= SS_INIT;
      run_cnt_q  <= RunReloadRst;
      exit_cnt_q <= '0;
      prep_cnt_q <= '0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      sys_q      <= sys_d;
      run_cnt_q  <= run_cnt_d;
      exit_cnt_q <= exit_cnt_d;
      prep_cnt_q <= prep_cnt_d;
    end
  end

  assign res_o.sys_state        = sys_d;
  assign res_o.phase            = phase_code(phase_d);
  assign res_o.enter_power_down = goto_hit;
  assign res_o.wake_seconds     = goto_hit ? cfg_i.wake_time : '0;

  a_pd_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (item_i.func != FUNC_TICK) |-> !goto_hit)
    else $error("power-down request on a command");

  a_cmd_keeps_sys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (item_i.func != FUNC_TICK) |=> $stable(sys_q))
    else $error("command changed system state");

  a_pd_stays_goto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && goto_hit && !item_i.continue_ok |=> phase_q == PH_GOTO)
    else $error("left goto phase without continue");

  a_goto_from_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && goto_hit |-> (phase_q == PH_PREP) || (phase_q == PH_GOTO))
    else $error("power-down request outside prepare or goto");

endmodule

### design/power_down_sequencer.sv
// Staged power-down sequencer (idle, run, exit-run, prepare, goto). Each transfer on
// in_i is a tick or a command and yields exactly one transfer on out_o carrying the
// system state, the phase after the item, and a power-down request with the wake time.
// One item is accepted per clock cycle while out_o is not stalled; each item passes
// the input register, then sequencer logic into the result register. Configuration via
// cfg_we_i, cfg_idx_i and cfg_data_i, to be written only while no items are in flight.
module power_down_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  pds_in_if.sink            in_i,
  pds_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import pds_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  s1_vld_q, out_vld_q;
  logic  in_xfer, s2_ld;

  pds_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pds_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s2_ld),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign s2_ld      = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s2_ld;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) s1_vld_q <= 1'b1;
      else if (s2_ld) s1_vld_q <= 1'b0;
      if (s2_ld) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.func        <= func_e'(in_i.func);
      item_q.run_time    <= in_i.run_time;
      item_q.exit_run_ok <= in_i.exit_run_ok;
      item_q.prepare_ok  <= in_i.prepare_ok;
      item_q.goto_ok     <= in_i.goto_ok;
      item_q.continue_ok <= in_i.continue_ok;
    end
    if (s2_ld) res_q <= res;
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.sys_state        = res_q.sys_state;
  assign out_o.phase            = res_q.phase;
  assign out_o.enter_power_down = res_q.enter_power_down;
  assign out_o.wake_seconds     = res_q.wake_seconds;

endmodule
